// File: design/sawarq_pkg.sv
// ----------------------------------------------------------------------------
// sawarq_pkg
// Shared types and constants of the stop-and-wait ARQ sender.
// ----------------------------------------------------------------------------
package sawarq_pkg;

    // request codes carried by req_type
    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_RX    = 2'd2;
    localparam logic [1:0] REQ_TICK  = 2'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_ACK_TIMEOUT   = 3'd0;
    localparam logic [2:0] CFG_MAX_ATTEMPTS  = 3'd1;
    localparam logic [2:0] CFG_NACK_BACKOFF  = 3'd2;
    localparam logic [2:0] CFG_ACK_CODE      = 3'd3;
    localparam logic [2:0] CFG_NACK_CODE     = 3'd4;

    // reset values of the configuration registers
    localparam logic [15:0] RST_ACK_TIMEOUT  = 16'd2000;
    localparam logic [7:0]  RST_MAX_ATTEMPTS = 8'd5;
    localparam logic [15:0] RST_NACK_BACKOFF = 16'd50;
    localparam logic [7:0]  RST_ACK_CODE     = 8'd0;
    localparam logic [7:0]  RST_NACK_CODE    = 8'd1;

    // frame header: type, seq high, seq low
    localparam int HDR_LEN = 3;
    // shortest reply that counts as a packet
    localparam logic [6:0] MIN_RX_LEN = 7'd3;

    typedef enum logic [1:0] {
        TMR_HOLD,
        TMR_INC,
        TMR_CLEAR
    } timer_op_t;

    // controller -> datapath
    typedef struct packed {
        logic      store_wr;     // write payload byte, bump count
        logic      frame_latch;  // latch type/seq, restart attempt count
        logic      tx_begin;     // new transmission: attempt+1, rewind position
        logic      tx_emit;      // push current frame byte to the output
        logic      st_emit;      // push the status item to the output
        logic      finish;       // chunk done: clear count, latch outcome
        logic      fail;         // outcome latched by finish
        timer_op_t timer_op;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic count_full;
        logic attempts_zero;
        logic attempts_left;
        logic rx_short;
        logic ack_match;
        logic is_nack;
        logic backoff_zero;
        logic timeout_hit;
        logic backoff_hit;
        logic tx_last;
        logic out_free;
    } dp_stat_t;

endpackage

// File: design/stop_and_wait_arq_sender.sv
// ----------------------------------------------------------------------------
// stop_and_wait_arq_sender
// Stop-and-wait retransmitting sender with chunk store and reply timer.
// ----------------------------------------------------------------------------
// Each input item is taken while the sender is idle, waiting for a reply or
// backing off. A start, a retry or a timeout that transmits emits the frame at
// one byte per cycle while the output is free (3 header bytes plus the stored
// payload, so up to MAX_PAYLOAD + 3 result items), then a status item when
// the chunk ends; no input item is taken while the frame or status is being
// pushed out. The output register lets the next item be accepted while the
// last result still waits. The chunk store is a memory with a registered read
// port, read one position ahead of the frame pointer. Configuration writes
// are always taken and should only be issued while no item is in progress.
// ----------------------------------------------------------------------------
module stop_and_wait_arq_sender import sawarq_pkg::*; #(
    parameter int MAX_PAYLOAD = 50
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [7:0]  s_payload_byte,
    input  logic [7:0]  s_pkt_type,
    input  logic [15:0] s_seq_num,
    input  logic [7:0]  s_rx_type,
    input  logic [15:0] s_rx_seq,
    input  logic [6:0]  s_rx_len,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_is_status,
    output logic [7:0]  m_tx_byte,
    output logic        m_last_byte,
    output logic        m_outcome,
    output logic [7:0]  m_attempts_used,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    sawarq_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .stat       (stat),
        .cmd        (cmd)
    );

    sawarq_dp #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_payload_byte  (s_payload_byte),
        .s_pkt_type      (s_pkt_type),
        .s_seq_num       (s_seq_num),
        .s_rx_type       (s_rx_type),
        .s_rx_seq        (s_rx_seq),
        .s_rx_len        (s_rx_len),
        .cmd             (cmd),
        .stat            (stat),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_is_status     (m_is_status),
        .m_tx_byte       (m_tx_byte),
        .m_last_byte     (m_last_byte),
        .m_outcome       (m_outcome),
        .m_attempts_used (m_attempts_used)
    );

    // never overwrite a result that has not been taken
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.tx_emit || cmd.st_emit) |-> stat.out_free)
        else $error("result pushed into a full output register");

    // loads past the store depth are dropped
    a_store_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.store_wr |-> !stat.count_full)
        else $error("write past end of chunk store");

    // frame emission and input acceptance are exclusive
    a_no_accept_tx: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> !(cmd.tx_emit || cmd.st_emit))
        else $error("item accepted during frame emission");

    // a pushed status item carries no frame byte
    a_status_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.st_emit |=> (m_valid && m_is_status && !m_last_byte && m_tx_byte == 8'd0))
        else $error("status item malformed");

endmodule

// File: design/sawarq_dp.sv
// ----------------------------------------------------------------------------
// sawarq_dp
// Datapath: configuration, chunk store, counters, timer and output register.
// ----------------------------------------------------------------------------
module sawarq_dp import sawarq_pkg::*; #(
    parameter int MAX_PAYLOAD = 50
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic [7:0]  s_payload_byte,
    input  logic [7:0]  s_pkt_type,
    input  logic [15:0] s_seq_num,
    input  logic [7:0]  s_rx_type,
    input  logic [15:0] s_rx_seq,
    input  logic [6:0]  s_rx_len,
    input  dp_cmd_t     cmd,
    output dp_stat_t    stat,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_is_status,
    output logic [7:0]  m_tx_byte,
    output logic        m_last_byte,
    output logic        m_outcome,
    output logic [7:0]  m_attempts_used
);

    localparam int CNT_W  = $clog2(MAX_PAYLOAD + 1);
    localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int POS_W  = $clog2(MAX_PAYLOAD + HDR_LEN);

    logic [15:0] ack_timeout_reg;
    logic [7:0]  max_attempts_reg;
    logic [15:0] nack_backoff_reg;
    logic [7:0]  ack_code_reg;
    logic [7:0]  nack_code_reg;

    logic [CNT_W-1:0]  count_reg;
    logic [7:0]        attempt_reg;
    logic [15:0]       timer_reg;
    logic [15:0]       timer_next;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic [7:0]        frame_type_reg;
    logic [15:0]       frame_seq_reg;
    logic              fail_reg;

    logic [7:0]        store [MAX_PAYLOAD];
    logic [7:0]        rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic [POS_W-1:0]  pos_off;
    logic [7:0]        frame_byte;
    logic              out_valid_reg;

    // saturating tick count
    assign timer_next = (timer_reg == 16'hFFFF) ? timer_reg : timer_reg + 16'd1;

    always_comb begin
        pos_next = pos_reg;
        if (cmd.tx_begin) begin
            pos_next = '0;
        end else if (cmd.tx_emit) begin
            pos_next = pos_reg + POS_W'(1);
        end
    end

    // read one position ahead so the registered data lines up with pos_reg
    assign pos_off = pos_next - POS_W'(HDR_LEN);
    assign rd_addr = (pos_next >= POS_W'(HDR_LEN)) ? pos_off[ADDR_W-1:0] : '0;

    always_comb begin
        if (pos_reg == POS_W'(0)) begin
            frame_byte = frame_type_reg;
        end else if (pos_reg == POS_W'(1)) begin
            frame_byte = frame_seq_reg[15:8];
        end else if (pos_reg == POS_W'(2)) begin
            frame_byte = frame_seq_reg[7:0];
        end else begin
            frame_byte = rd_data_reg;
        end
    end

    assign stat.count_full    = (count_reg == CNT_W'(MAX_PAYLOAD));
    assign stat.attempts_zero = (max_attempts_reg == 8'd0);
    assign stat.attempts_left = (attempt_reg < max_attempts_reg);
    assign stat.rx_short      = (s_rx_len < MIN_RX_LEN);
    assign stat.ack_match     = (s_rx_type == ack_code_reg) && (s_rx_seq == frame_seq_reg);
    assign stat.is_nack       = (s_rx_type == nack_code_reg);
    assign stat.backoff_zero  = (nack_backoff_reg == 16'd0);
    assign stat.timeout_hit   = (timer_next >= ack_timeout_reg);
    assign stat.backoff_hit   = (timer_next >= nack_backoff_reg);
    assign stat.tx_last       = (pos_reg == POS_W'(count_reg) + POS_W'(HDR_LEN - 1));
    assign stat.out_free      = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ack_timeout_reg  <= RST_ACK_TIMEOUT;
            max_attempts_reg <= RST_MAX_ATTEMPTS;
            nack_backoff_reg <= RST_NACK_BACKOFF;
            ack_code_reg     <= RST_ACK_CODE;
            nack_code_reg    <= RST_NACK_CODE;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_ACK_TIMEOUT:  ack_timeout_reg  <= cfg_data;
                CFG_MAX_ATTEMPTS: max_attempts_reg <= cfg_data[7:0];
                CFG_NACK_BACKOFF: nack_backoff_reg <= cfg_data;
                CFG_ACK_CODE:     ack_code_reg     <= cfg_data[7:0];
                CFG_NACK_CODE:    nack_code_reg    <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            attempt_reg   <= '0;
            timer_reg     <= '0;
            pos_reg       <= '0;
            fail_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            pos_reg <= pos_next;
            if (cmd.store_wr) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (cmd.finish) begin
                count_reg <= '0;
            end
            if (cmd.frame_latch) begin
                attempt_reg <= cmd.tx_begin ? 8'd1 : 8'd0;
            end else if (cmd.tx_begin) begin
                attempt_reg <= attempt_reg + 8'd1;
            end
            case (cmd.timer_op)
                TMR_INC:   timer_reg <= timer_next;
                TMR_CLEAR: timer_reg <= '0;
                default:   ;
            endcase
            if (cmd.finish) begin
                fail_reg <= cmd.fail;
            end
            if (cmd.tx_emit || cmd.st_emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.frame_latch) begin
            frame_type_reg <= s_pkt_type;
            frame_seq_reg  <= s_seq_num;
        end
        if (cmd.store_wr) begin
            store[count_reg[ADDR_W-1:0]] <= s_payload_byte;
        end
        rd_data_reg <= store[rd_addr];
        if (cmd.tx_emit) begin
            m_is_status     <= 1'b0;
            m_tx_byte       <= frame_byte;
            m_last_byte     <= stat.tx_last;
            m_outcome       <= 1'b0;
            m_attempts_used <= attempt_reg;
        end else if (cmd.st_emit) begin
            m_is_status     <= 1'b1;
            m_tx_byte       <= 8'd0;
            m_last_byte     <= 1'b0;
            m_outcome       <= fail_reg;
            m_attempts_used <= attempt_reg;
        end
    end

    assign m_valid = out_valid_reg;

endmodule

// File: design/sawarq_ctrl.sv
// ----------------------------------------------------------------------------
// sawarq_ctrl
// Controller: protocol phase, frame emission and status sequencing.
// ----------------------------------------------------------------------------
module sawarq_ctrl import sawarq_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_req_type,
    input  dp_stat_t   stat,
    output dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WAIT,
        ST_BACKOFF,
        ST_TX,
        ST_STATUS
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_ready = (state_reg == ST_IDLE) || (state_reg == ST_WAIT) ||
                     (state_reg == ST_BACKOFF);
    assign accept  = s_valid && s_ready;

    always_comb begin
        cmd        = '0;
        cmd.timer_op = TMR_HOLD;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && s_req_type == REQ_LOAD && !stat.count_full) begin
                    cmd.store_wr = 1'b1;
                end else if (accept && s_req_type == REQ_START) begin
                    cmd.frame_latch = 1'b1;
                    cmd.timer_op    = TMR_CLEAR;
                    if (stat.attempts_zero) begin
                        cmd.finish = 1'b1;
                        cmd.fail   = 1'b1;
                        state_next = ST_STATUS;
                    end else begin
                        cmd.tx_begin = 1'b1;
                        state_next   = ST_TX;
                    end
                end
            end
            ST_WAIT, ST_BACKOFF: begin
                if (accept) begin
                    // retry_or_fail is the default outcome of a trigger below
                    if (state_reg == ST_WAIT && s_req_type == REQ_RX && !stat.rx_short) begin
                        cmd.timer_op = TMR_CLEAR;
                        if (stat.ack_match) begin
                            cmd.finish = 1'b1;
                            state_next = ST_STATUS;
                        end else if (stat.is_nack && !stat.backoff_zero) begin
                            state_next = ST_BACKOFF;
                        end else if (stat.attempts_left) begin
                            cmd.tx_begin = 1'b1;
                            state_next   = ST_TX;
                        end else begin
                            cmd.finish = 1'b1;
                            cmd.fail   = 1'b1;
                            state_next = ST_STATUS;
                        end
                    end else if (s_req_type == REQ_TICK) begin
                        if ((state_reg == ST_WAIT && stat.timeout_hit) ||
                            (state_reg == ST_BACKOFF && stat.backoff_hit)) begin
                            cmd.timer_op = TMR_CLEAR;
                            if (stat.attempts_left) begin
                                cmd.tx_begin = 1'b1;
                                state_next   = ST_TX;
                            end else begin
                                cmd.finish = 1'b1;
                                cmd.fail   = 1'b1;
                                state_next = ST_STATUS;
                            end
                        end else begin
                            cmd.timer_op = TMR_INC;
                        end
                    end
                end
            end
            ST_TX: begin
                if (stat.out_free) begin
                    cmd.tx_emit = 1'b1;
                    if (stat.tx_last) begin
                        state_next = ST_WAIT;
                    end
                end
            end
            ST_STATUS: begin
                if (stat.out_free) begin
                    cmd.st_emit = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: tb/stop_and_wait_arq_sender_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stop_and_wait_arq_sender_tb
// Self-checking bench for the stop-and-wait ARQ sender. A scoreboard class
// mirrors the sender's phases, chunk store and retry counting, builds the
// frame bytes and status items that each accepted input item should cause,
// and checks every result item in order. Directed corner cases come first,
// then randomized chunks under several register settings with random gaps
// on both channels and one long output stall.
// ----------------------------------------------------------------------------
module stop_and_wait_arq_sender_tb;
    import sawarq_pkg::*;

    localparam int          CHUNK_MAX        = 50;
    localparam int          RANDOM_ITEMS     = 100;
    localparam int          GAP_MAX          = 17;
    localparam int          SETTLE_CYCLES    = 16;
    localparam int          DRAIN_LIMIT      = 5000;
    localparam int          CYCLE_LIMIT      = 2000000;
    localparam int          PRESSURE_HOLD    = 300;
    // NACKs are only sent while the backoff stays short enough to tick through
    localparam logic [15:0] NACK_BACKOFF_CAP = 16'd20;
    localparam logic [2:0]  CFG_UNUSED       = 3'd7;

    typedef enum logic [1:0] {
        ARQ_IDLE,
        ARQ_WAIT,
        ARQ_BACKOFF
    } arq_phase_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  payload_byte;
        logic [7:0]  pkt_type;
        logic [15:0] seq_num;
        logic [7:0]  rx_type;
        logic [15:0] rx_seq;
        logic [6:0]  rx_len;
    } arq_req_t;

    typedef struct packed {
        logic       is_status;
        logic [7:0] tx_byte;
        logic       last_byte;
        logic       outcome;
        logic [7:0] attempts_used;
    } arq_out_t;

    class arq_scoreboard;
        logic [15:0] cfg_timeout;
        logic [7:0]  cfg_attempts;
        logic [15:0] cfg_backoff;
        logic [7:0]  cfg_ack;
        logic [7:0]  cfg_nack;
        arq_phase_t  phase;
        logic [7:0]  attempt_count;
        logic [15:0] wait_timer;
        logic [7:0]  chunk[CHUNK_MAX];
        int          chunk_len;
        logic [7:0]  frame_type;
        logic [15:0] frame_seq;
        arq_out_t    pending[$];
        int          n_effective;
        int          n_frames;
        int          n_acked;
        int          n_failed;
        int          n_checked;
        int          n_errors;

        function new();
            cfg_timeout   = RST_ACK_TIMEOUT;
            cfg_attempts  = RST_MAX_ATTEMPTS;
            cfg_backoff   = RST_NACK_BACKOFF;
            cfg_ack       = RST_ACK_CODE;
            cfg_nack      = RST_NACK_CODE;
            phase         = ARQ_IDLE;
            attempt_count = '0;
            wait_timer    = '0;
            chunk_len     = 0;
            frame_type    = '0;
            frame_seq     = '0;
            foreach (chunk[i]) chunk[i] = '0;
            n_effective = 0;
            n_frames    = 0;
            n_acked     = 0;
            n_failed    = 0;
            n_checked   = 0;
            n_errors    = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [15:0] data);
            case (idx)
                CFG_ACK_TIMEOUT:  cfg_timeout  = data;
                CFG_MAX_ATTEMPTS: cfg_attempts = data[7:0];
                CFG_NACK_BACKOFF: cfg_backoff  = data;
                CFG_ACK_CODE:     cfg_ack      = data[7:0];
                CFG_NACK_CODE:    cfg_nack     = data[7:0];
                default: ;
            endcase
        endfunction

        function void push_byte(logic [7:0] b, logic last);
            pending.push_back('{1'b0, b, last, 1'b0, attempt_count});
        endfunction

        function void close_chunk(logic failed);
            pending.push_back('{1'b1, 8'h00, 1'b0, failed, attempt_count});
            if (failed) n_failed++;
            else n_acked++;
            phase      = ARQ_IDLE;
            wait_timer = '0;
            chunk_len  = 0;
        endfunction

        function void transmit_frame();
            attempt_count = attempt_count + 8'd1;
            n_frames++;
            push_byte(frame_type, 1'b0);
            push_byte(frame_seq[15:8], 1'b0);
            push_byte(frame_seq[7:0], chunk_len == 0);
            for (int i = 0; i < chunk_len; i++)
                push_byte(chunk[i], i + 1 == chunk_len);
            phase      = ARQ_WAIT;
            wait_timer = '0;
        endfunction

        function void retry_or_fail();
            if (attempt_count >= cfg_attempts) close_chunk(1'b1);
            else transmit_frame();
        endfunction

        function void note_item(arq_req_t it);
            case (it.req_type)
                REQ_LOAD: begin
                    if (phase == ARQ_IDLE && chunk_len < CHUNK_MAX) begin
                        chunk[chunk_len] = it.payload_byte;
                        chunk_len++;
                        n_effective++;
                    end
                end
                REQ_START: begin
                    if (phase == ARQ_IDLE) begin
                        n_effective++;
                        frame_type    = it.pkt_type;
                        frame_seq     = it.seq_num;
                        attempt_count = '0;
                        wait_timer    = '0;
                        if (cfg_attempts == 8'd0) close_chunk(1'b1);
                        else transmit_frame();
                    end
                end
                REQ_RX: begin
                    if (phase == ARQ_WAIT && it.rx_len >= MIN_RX_LEN) begin
                        n_effective++;
                        if (it.rx_type == cfg_ack && it.rx_seq == frame_seq) begin
                            close_chunk(1'b0);
                        end else if (it.rx_type == cfg_nack) begin
                            if (cfg_backoff == 16'd0) begin
                                retry_or_fail();
                            end else begin
                                phase      = ARQ_BACKOFF;
                                wait_timer = '0;
                            end
                        end else begin
                            retry_or_fail();
                        end
                    end
                end
                default: begin
                    if (phase != ARQ_IDLE) begin
                        n_effective++;
                        if (wait_timer != 16'hFFFF) wait_timer = wait_timer + 16'd1;
                        if (phase == ARQ_WAIT) begin
                            if (wait_timer >= cfg_timeout) retry_or_fail();
                        end else if (wait_timer >= cfg_backoff) begin
                            retry_or_fail();
                        end
                    end
                end
            endcase
        endfunction

        function void report(string field, logic [7:0] want, logic [7:0] got);
            $error("%s: expected %0d, got %0d", field, want, got);
            n_errors++;
        endfunction

        function void check_result(arq_out_t got);
            arq_out_t want;
            if (pending.size() == 0) begin
                $error("result item with nothing expected: is_status %0d tx_byte %0d",
                       got.is_status, got.tx_byte);
                n_errors++;
                return;
            end
            want = pending.pop_front();
            n_checked++;
            if (got.is_status !== want.is_status)
                report("is_status", 8'(want.is_status), 8'(got.is_status));
            if (got.tx_byte !== want.tx_byte)
                report("tx_byte", want.tx_byte, got.tx_byte);
            if (got.last_byte !== want.last_byte)
                report("last_byte", 8'(want.last_byte), 8'(got.last_byte));
            if (got.outcome !== want.outcome)
                report("outcome", 8'(want.outcome), 8'(got.outcome));
            if (got.attempts_used !== want.attempts_used)
                report("attempts_used", want.attempts_used, got.attempts_used);
        endfunction
    endclass

    logic        aclk           = 1'b0;
    logic        aresetn        = 1'b0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic [1:0]  s_req_type     = '0;
    logic [7:0]  s_payload_byte = '0;
    logic [7:0]  s_pkt_type     = '0;
    logic [15:0] s_seq_num      = '0;
    logic [7:0]  s_rx_type      = '0;
    logic [15:0] s_rx_seq       = '0;
    logic [6:0]  s_rx_len       = '0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic        m_is_status;
    logic [7:0]  m_tx_byte;
    logic        m_last_byte;
    logic        m_outcome;
    logic [7:0]  m_attempts_used;
    logic        cfg_valid      = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index      = '0;
    logic [15:0] cfg_data       = '0;

    arq_scoreboard sb;
    bit  src_gaps    = 1'b0;
    bit  sink_gaps   = 1'b0;
    int  sink_hold   = 0;
    int  n_settings  = 0;
    int  cycle_count = 0;

    stop_and_wait_arq_sender #(.MAX_PAYLOAD(CHUNK_MAX)) dut (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // all handshakes are observed here, inputs are stable at the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                sb.set_reg(cfg_index, cfg_data);
            if (s_valid && s_ready)
                sb.note_item('{s_req_type, s_payload_byte, s_pkt_type, s_seq_num,
                               s_rx_type, s_rx_seq, s_rx_len});
            if (m_valid && m_ready)
                sb.check_result('{m_is_status, m_tx_byte, m_last_byte, m_outcome,
                                  m_attempts_used});
        end
    end

    initial begin : result_sink
        int stall;
        int hold;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            hold      = sink_hold;
            sink_hold = 0;
            stall     = sink_gaps ? $urandom_range(0, GAP_MAX) : 0;
            if (hold > 0 || stall > 0) begin
                m_ready <= 1'b0;
                repeat (hold + stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
    endtask

    // upper bits of the byte-wide registers carry junk that must be dropped
    task automatic program_regs(input logic [15:0] tmo, input logic [7:0] tries,
                                input logic [15:0] pause, input logic [7:0] ack_c,
                                input logic [7:0] nack_c);
        logic [7:0] junk;
        write_reg(CFG_ACK_TIMEOUT, tmo);
        junk = 8'($urandom_range(0, 255));
        write_reg(CFG_MAX_ATTEMPTS, {junk, tries});
        write_reg(CFG_NACK_BACKOFF, pause);
        junk = 8'($urandom_range(0, 255));
        write_reg(CFG_ACK_CODE, {junk, ack_c});
        junk = 8'($urandom_range(0, 255));
        write_reg(CFG_NACK_CODE, {junk, nack_c});
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    function automatic arq_req_t random_item(logic [1:0] req);
        arq_req_t it;
        it.req_type     = req;
        it.payload_byte = 8'($urandom_range(0, 255));
        it.pkt_type     = 8'($urandom_range(0, 255));
        it.seq_num      = 16'($urandom_range(0, 65535));
        it.rx_type      = 8'($urandom_range(0, 255));
        it.rx_seq       = 16'($urandom_range(0, 65535));
        it.rx_len       = 7'($urandom_range(0, 127));
        return it;
    endfunction

    task automatic send_item(input arq_req_t it);
        int gap;
        gap = src_gaps ? $urandom_range(0, GAP_MAX) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_req_type     <= it.req_type;
        s_payload_byte <= it.payload_byte;
        s_pkt_type     <= it.pkt_type;
        s_seq_num      <= it.seq_num;
        s_rx_type      <= it.rx_type;
        s_rx_seq       <= it.rx_seq;
        s_rx_len       <= it.rx_len;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic send_load(input logic [7:0] b);
        arq_req_t it;
        it = random_item(REQ_LOAD);
        it.payload_byte = b;
        send_item(it);
    endtask

    task automatic send_start(input logic [7:0] pt, input logic [15:0] sq);
        arq_req_t it;
        it = random_item(REQ_START);
        it.pkt_type = pt;
        it.seq_num  = sq;
        send_item(it);
    endtask

    task automatic send_rx(input logic [7:0] rt, input logic [15:0] rs, input logic [6:0] rl);
        arq_req_t it;
        it = random_item(REQ_RX);
        it.rx_type = rt;
        it.rx_seq  = rs;
        it.rx_len  = rl;
        send_item(it);
    endtask

    task automatic send_tick();
        send_item(random_item(REQ_TICK));
    endtask

    // sender goes quiet until every expected result item is out
    task automatic drain_block();
        int waited;
        waited = 0;
        s_valid <= 1'b0;
        while (sb.pending.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (sb.pending.size() != 0) begin
            $error("%0d expected result items never arrived", sb.pending.size());
            sb.n_errors++;
            sb.pending.delete();
        end
    endtask

    // one reply-side item chosen from the current phase
    task automatic step_reply();
        int r;
        logic [7:0] rt;
        r = $urandom_range(0, 99);
        if (sb.phase == ARQ_BACKOFF) begin
            if (r < 80) send_tick();
            else if (r < 87) send_item(random_item(REQ_LOAD));
            else if (r < 94) send_item(random_item(REQ_START));
            else send_item(random_item(REQ_RX));
        end else if (r < 40) begin
            send_rx(sb.cfg_ack, sb.frame_seq, 7'($urandom_range(3, 127)));
        end else if (r < 55 && sb.cfg_backoff <= NACK_BACKOFF_CAP) begin
            send_rx(sb.cfg_nack, 16'($urandom_range(0, 65535)), 7'($urandom_range(3, 127)));
        end else if (r < 68) begin
            rt = 8'($urandom_range(0, 255));
            if (rt == sb.cfg_nack && sb.cfg_backoff > NACK_BACKOFF_CAP) rt = ~rt;
            send_rx(rt, 16'($urandom_range(0, 65535)), 7'($urandom_range(3, 127)));
        end else if (r < 74 && (sb.cfg_ack != sb.cfg_nack || sb.cfg_backoff <= NACK_BACKOFF_CAP))
        begin
            send_rx(sb.cfg_ack, sb.frame_seq ^ (16'h1 << $urandom_range(0, 15)),
                    7'($urandom_range(3, 127)));
        end else if (r < 80) begin
            send_rx(sb.cfg_ack, sb.frame_seq, 7'($urandom_range(0, 2)));
        end else if (r < 95) begin
            send_tick();
        end else begin
            send_item(random_item(r[0] ? REQ_LOAD : REQ_START));
        end
    endtask

    task automatic run_chunk(input int n_bytes);
        repeat (n_bytes) send_load(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 4) == 0)
            send_item(random_item($urandom_range(0, 1) ? REQ_TICK : REQ_RX));
        send_start(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
        while (sb.phase != ARQ_IDLE) step_reply();
    endtask

    initial begin : stimulus
        int base;
        int chunk_no;
        int n_bytes;
        logic [7:0] ack_c;
        logic [7:0] nack_c;

        sb = new();
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: short timeout, two attempts, short backoff
        program_regs(16'd3, 8'd2, 16'd2, 8'hA5, 8'h5A);
        send_start(8'hFF, 16'hFFFF);             // empty payload, seq low byte is last
        send_rx(8'hA5, 16'hFFFF, 7'd2);          // too short, ignored
        send_rx(8'hA5, 16'h0000, 7'd3);          // ack for another seq -> resend
        send_rx(8'h5A, 16'h1234, 7'd3);          // NACK on the last attempt
        send_load(8'h3C);                        // ignored while backing off
        send_start(8'h11, 16'h2222);             // ignored while backing off
        send_tick();
        send_tick();                             // backoff over -> failure
        send_tick();                             // ignored in idle
        send_rx(8'hA5, 16'hFFFF, 7'd64);         // ignored in idle
        send_load(8'h00);
        send_load(8'hFF);
        send_start(8'h00, 16'h0000);
        repeat (3) send_tick();                  // timeout -> resend
        send_rx(8'hA5, 16'h0000, 7'd127);        // ack -> success
        drain_block();

        // zero timeout, zero attempts, ack and nack share a code
        write_reg(CFG_UNUSED, 16'($urandom_range(0, 65535)));
        program_regs(16'd0, 8'd0, 16'd0, 8'h33, 8'h33);
        send_start(8'h5A, 16'hA5A5);             // fails at once, nothing sent
        drain_block();

        program_regs(16'd0, 8'd2, 16'd0, 8'h33, 8'h33);
        send_start(8'h80, 16'h8001);
        send_rx(8'h33, 16'h0001, 7'd3);          // wrong seq, counts as NACK, no backoff
        send_tick();                             // first tick times out -> failure

        base     = sb.n_effective;
        chunk_no = 0;
        while (sb.n_effective - base < RANDOM_ITEMS) begin
            if (chunk_no % 3 == 0) begin
                drain_block();
                case ((chunk_no / 3) % 3)
                    0: begin
                        ack_c  = 8'($urandom_range(0, 255));
                        nack_c = ($urandom_range(0, 3) == 0) ? ack_c :
                                 8'($urandom_range(0, 255));
                        program_regs(16'($urandom_range(1, 12)),
                                     chunk_no == 0 ? 8'd3 : 8'($urandom_range(0, 6)),
                                     16'($urandom_range(0, 6)), ack_c, nack_c);
                    end
                    1: program_regs(16'hFFFF, 8'hFF, 16'hFFFF, 8'h00, 8'hFF);
                    default: program_regs(16'd1, 8'd1, 16'd0, 8'hFF, 8'h00);
                endcase
            end
            src_gaps  = $urandom_range(0, 3) != 0;
            sink_gaps = $urandom_range(0, 3) != 0;
            if (chunk_no == 0) begin
                // long output stall while items keep coming
                sink_hold = PRESSURE_HOLD;
                n_bytes   = 16;
            end else if (chunk_no == 1 || $urandom_range(0, 11) == 0) begin
                n_bytes = $urandom_range(CHUNK_MAX + 1, CHUNK_MAX + 6);
            end else begin
                n_bytes = $urandom_range(0, 8);
            end
            run_chunk(n_bytes);
            chunk_no++;
        end

        drain_block();
        $display("covered %0d state-changing items in %0d random chunks over %0d settings",
                 sb.n_effective, chunk_no, n_settings);
        $display("%0d transmissions, %0d chunks acked, %0d failed, %0d result items checked",
                 sb.n_frames, sb.n_acked, sb.n_failed, sb.n_checked);
        if (sb.n_errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
